/* src/sog_pkg.sv */
// Shared types, constants and helpers for the spiral order address generator.
// No dependencies; used by every module of the block.
package sog_pkg;

  localparam int MAX_DIM = 256;
  localparam int DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int CNT_W   = 2 * COORD_W + 1;
  localparam int TOT_W   = 2 * DIM_W;
  localparam int FILL_W  = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_COUNT   = 2'd0,
    REG_COL_COUNT   = 2'd1,
    REG_START_VALUE = 2'd2,
    REG_CLOCKWISE   = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    SIDE_FWD  = 4'b0001,
    SIDE_DOWN = 4'b0010,
    SIDE_BACK = 4'b0100,
    SIDE_UP   = 4'b1000
  } side_t;

  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [FILL_W-1:0] start;
    logic              cw;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [FILL_W-1:0]  fill;
    logic               last;
  } res_t;

  // zero reads as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

/* src/spiral_order_address_generator_top.sv */
// Spiral order address generator: one matrix cell per beat in spiral order.
// Output: a result is registered and presented in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output is not stalled; the walk registers advance in a single pass.
// Reset: 1x1 matrix, start value 0, clockwise, walk at the first cell.
// Any configuration write restarts the walk at the first cell.
// Depends on sog_pkg, sog_walker and sog_out_stage.
module spiral_order_address_generator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sog_pkg::COORD_W-1:0]         out_row_index,
  output logic [sog_pkg::COORD_W-1:0]         out_col_index,
  output logic signed [sog_pkg::FILL_W-1:0]   out_fill_value,
  output logic                                out_last_cell,
  input  logic                                cfg_we,
  input  logic [sog_pkg::IDX_W-1:0]           cfg_index,
  input  logic [sog_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [sog_pkg::DIM_W-1:0]  row_count_r, col_count_r;
  logic [sog_pkg::FILL_W-1:0] start_value_r;
  logic                       clockwise_r;
  sog_pkg::cfg_t              cfg;
  sog_pkg::res_t              step_res, out_res;
  logic                       in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= sog_pkg::DIM_W'(1);
      col_count_r   <= sog_pkg::DIM_W'(1);
      start_value_r <= '0;
      clockwise_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (sog_pkg::reg_idx_t'(cfg_index))
        sog_pkg::REG_ROW_COUNT:   row_count_r   <= cfg_wdata[sog_pkg::DIM_W-1:0];
        sog_pkg::REG_COL_COUNT:   col_count_r   <= cfg_wdata[sog_pkg::DIM_W-1:0];
        sog_pkg::REG_START_VALUE: start_value_r <= cfg_wdata[sog_pkg::FILL_W-1:0];
        sog_pkg::REG_CLOCKWISE:   clockwise_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.rows  = sog_pkg::clamp_dim(row_count_r);
  assign cfg.cols  = sog_pkg::clamp_dim(col_count_r);
  assign cfg.start = start_value_r;
  assign cfg.cw    = clockwise_r;

  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  sog_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .step        (in_acc),
    .restart     (in_restart),
    .cfg_restart (cfg_we),
    .res         (step_res)
  );

  sog_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .res       (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_row_index  = out_res.row;
  assign out_col_index  = out_res.col;
  assign out_fill_value = $signed(out_res.fill);
  assign out_last_cell  = out_res.last;

endmodule

/* src/sog_walker.sv */
// Walk state and single-pass step logic: emits the current cell and moves on.
// Depends on sog_pkg.
module sog_walker (
  input  logic          clk,
  input  logic          rst_n,
  input  sog_pkg::cfg_t cfg,
  input  logic          step,
  input  logic          restart,
  input  logic          cfg_restart,
  output sog_pkg::res_t res
);

  logic [sog_pkg::COORD_W-1:0] cur_row_r, cur_row_nxt;
  logic [sog_pkg::COORD_W-1:0] cur_col_r, cur_col_nxt;
  logic [sog_pkg::COORD_W-1:0] ring_r, ring_nxt;
  sog_pkg::side_t              side_r, side_nxt;
  logic [sog_pkg::CNT_W-1:0]   cells_done_r, cells_done_nxt;

  logic [sog_pkg::COORD_W-1:0] row_s, col_s, ring_s;
  sog_pkg::side_t              side_s;
  logic [sog_pkg::CNT_W-1:0]   cnt_s;
  logic [sog_pkg::COORD_W-1:0] a, b, a_new, b_new, ring_new;
  logic [sog_pkg::DIM_W-1:0]   na, nb, bot, right, a9, b9, ring9;
  sog_pkg::side_t              side_new;
  logic [sog_pkg::TOT_W-1:0]   total;
  logic                        last;

  assign total = sog_pkg::TOT_W'(cfg.rows) * sog_pkg::TOT_W'(cfg.cols);

  always_comb begin
    row_s  = restart ? '0 : cur_row_r;
    col_s  = restart ? '0 : cur_col_r;
    ring_s = restart ? '0 : ring_r;
    side_s = restart ? sog_pkg::SIDE_FWD : side_r;
    cnt_s  = restart ? '0 : cells_done_r;

    a  = cfg.cw ? row_s : col_s;
    b  = cfg.cw ? col_s : row_s;
    na = cfg.cw ? cfg.rows : cfg.cols;
    nb = cfg.cw ? cfg.cols : cfg.rows;
    a9    = {1'b0, a};
    b9    = {1'b0, b};
    ring9 = {1'b0, ring_s};
    bot   = na - sog_pkg::DIM_W'(1) - ring9;
    right = nb - sog_pkg::DIM_W'(1) - ring9;

    a_new    = a;
    b_new    = b;
    ring_new = ring_s;
    side_new = side_s;
    unique case (side_s)
      sog_pkg::SIDE_FWD: begin
        if (b9 < right) b_new = b + 1'b1;
        else begin
          side_new = sog_pkg::SIDE_DOWN;
          a_new    = a + 1'b1;
        end
      end
      sog_pkg::SIDE_DOWN: begin
        if (a9 < bot) a_new = a + 1'b1;
        else begin
          side_new = sog_pkg::SIDE_BACK;
          b_new    = b - 1'b1;
        end
      end
      sog_pkg::SIDE_BACK: begin
        if (b > ring_s) b_new = b - 1'b1;
        else begin
          side_new = sog_pkg::SIDE_UP;
          a_new    = a - 1'b1;
        end
      end
      sog_pkg::SIDE_UP: begin
        if (a9 > ring9 + sog_pkg::DIM_W'(1)) a_new = a - 1'b1;
        else begin
          ring_new = ring_s + 1'b1;
          side_new = sog_pkg::SIDE_FWD;
          b_new    = b + 1'b1;
        end
      end
      default: begin
        side_new = sog_pkg::SIDE_FWD;
      end
    endcase

    last = ({1'b0, cnt_s} + sog_pkg::TOT_W'(1)) >= total;

    res.row  = row_s;
    res.col  = col_s;
    res.fill = cfg.start + sog_pkg::FILL_W'(cnt_s);
    res.last = last;

    if (last) begin
      cur_row_nxt    = '0;
      cur_col_nxt    = '0;
      ring_nxt       = '0;
      side_nxt       = sog_pkg::SIDE_FWD;
      cells_done_nxt = '0;
    end else begin
      cur_row_nxt    = cfg.cw ? a_new : b_new;
      cur_col_nxt    = cfg.cw ? b_new : a_new;
      ring_nxt       = ring_new;
      side_nxt       = side_new;
      cells_done_nxt = cnt_s + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      ring_r       <= '0;
      side_r       <= sog_pkg::SIDE_FWD;
      cells_done_r <= '0;
    end else if (step) begin
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      ring_r       <= ring_nxt;
      side_r       <= side_nxt;
      cells_done_r <= cells_done_nxt;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cells_done_r} < total)
    else $error("cell count beyond matrix size");

  a_pos_in_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_row_r} < cfg.rows) && ({1'b0, cur_col_r} < cfg.cols))
    else $error("walk left the matrix");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last) |=> (cells_done_r == '0 && cur_row_r == '0 && cur_col_r == '0))
    else $error("walk did not restart after final cell");

endmodule

/* src/sog_out_stage.sv */
// Result register: holds one beat until the downstream side takes it.
// Depends on sog_pkg.
module sog_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  sog_pkg::res_t res,
  input  logic          out_stall,
  output logic          out_valid,
  output sog_pkg::res_t out_res
);

  logic          valid_r;
  sog_pkg::res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
